// ----- hw/rtl/mkd_pkg.sv -----
// Package for the Morse key decoder: field widths, reset constants and the
// Morse character table. No dependencies.
package mkd_pkg;

  localparam int THR_W = 16;
  localparam int CHAR_W = 7;

  localparam int MAX_ELEMENTS_DEF = 5;
  localparam int TABLE_ELEMENTS = 5;

  localparam logic [THR_W-1:0] DAH_THRESHOLD_RESET = 16'd1000;
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd43;

  // Index is a leading one above the pattern, MSB-first, dah = 1.
  function automatic logic [CHAR_W-1:0] morse_lookup(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    c = CHAR_UNKNOWN;
    case (idx)
      6'd2: c = 7'(8'h45); 6'd3: c = 7'(8'h54);
      6'd4: c = 7'(8'h49); 6'd5: c = 7'(8'h41);
      6'd6: c = 7'(8'h4E); 6'd7: c = 7'(8'h4D);
      6'd8: c = 7'(8'h53); 6'd9: c = 7'(8'h55);
      6'd10: c = 7'(8'h52); 6'd11: c = 7'(8'h57);
      6'd12: c = 7'(8'h44); 6'd13: c = 7'(8'h4B);
      6'd14: c = 7'(8'h47); 6'd15: c = 7'(8'h4F);
      6'd16: c = 7'(8'h48); 6'd17: c = 7'(8'h56);
      6'd18: c = 7'(8'h46); 6'd20: c = 7'(8'h4C);
      6'd22: c = 7'(8'h50); 6'd23: c = 7'(8'h4A);
      6'd24: c = 7'(8'h42); 6'd25: c = 7'(8'h58);
      6'd26: c = 7'(8'h43); 6'd27: c = 7'(8'h59);
      6'd28: c = 7'(8'h5A); 6'd29: c = 7'(8'h51);
      6'd32: c = 7'(8'h35); 6'd33: c = 7'(8'h34);
      6'd35: c = 7'(8'h33); 6'd39: c = 7'(8'h32);
      6'd47: c = 7'(8'h31); 6'd48: c = 7'(8'h36);
      6'd56: c = 7'(8'h37); 6'd60: c = 7'(8'h38);
      6'd62: c = 7'(8'h39); 6'd63: c = 7'(8'h30);
      default: c = CHAR_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/mkd_key_if.sv -----
// Input channel of the Morse key decoder: one key sample per beat.
// Depends on nothing.
interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

// ----- hw/rtl/mkd_char_if.sv -----
// Output channel of the Morse key decoder: one character status per beat.
// Depends on mkd_pkg for the character width.
interface mkd_char_if
  import mkd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              char_done;

  modport source (output valid, output char_code, output char_done, input ready);
  modport sink (input valid, input char_code, input char_done, output ready);
endinterface

// ----- hw/rtl/morse_key_decoder.sv -----
// Morse key decoder top level. Depends on mkd_pkg, mkd_key_if and mkd_char_if.
// Each result beat is registered in the output register at the edge that
// accepts its key beat. Throughput: one key beat per cycle while the downstream
// side takes each result; a result that is not taken holds off the next key beat.
// Reset (rst, synchronous, active high) clears the key state, tick counter and
// pattern, sets the last character to '+' and the threshold to 1000 ticks.
module morse_key_decoder
  import mkd_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              dah_threshold_we,
  input  logic [THR_W-1:0]  dah_threshold_wdata,
  mkd_key_if.sink           key_in,
  mkd_char_if.source        char_out
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  // Configuration and decoder state.
  logic [THR_W-1:0]        dah_threshold;
  logic                    key_pressed;
  logic [THR_W-1:0]        tick_count;
  logic [MAX_ELEMENTS-1:0] element_bits;
  logic [CNT_W-1:0]        element_count;
  logic [CHAR_W-1:0]       last_char;

  // Output register.
  logic              out_valid;
  logic [CHAR_W-1:0] out_code;
  logic              out_done;

  logic accept;

  logic                    key_released;
  logic                    press_edge;
  logic                    release_edge;
  logic [THR_W-1:0]        tick_inc;
  logic [THR_W-1:0]        tick_after_edge;
  logic                    is_dah;
  logic                    can_append;
  logic [MAX_ELEMENTS-1:0] bits_app;
  logic [CNT_W-1:0]        cnt_app;
  logic                    pattern_full;
  logic                    gap_end;
  logic                    do_decode;
  logic [CNT_W-1:0]        shamt;
  logic [4:0]              code5;
  logic [5:0]              lead;
  logic [5:0]              table_idx;
  logic [CHAR_W-1:0]       decoded;

  logic                    key_pressed_next;
  logic [THR_W-1:0]        tick_count_next;
  logic [MAX_ELEMENTS-1:0] element_bits_next;
  logic [CNT_W-1:0]        element_count_next;
  logic [CHAR_W-1:0]       last_char_next;

  // The output register frees up when empty or when its beat is taken, so a
  // new key beat is accepted in the same cycle the old result leaves.
  assign key_in.ready = !out_valid || char_out.ready;
  assign accept = key_in.valid && key_in.ready;

  assign char_out.valid = out_valid;
  assign char_out.char_code = out_code;
  assign char_out.char_done = out_done;

  always_comb begin
    key_released = key_in.key_level;
    press_edge = !key_pressed && !key_released;
    release_edge = key_pressed && key_released;

    // The tick counter saturates at all ones instead of wrapping.
    tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
    tick_after_edge = (press_edge || release_edge) ? '0 : tick_inc;

    // A press that lasted at least the threshold is a dah.
    is_dah = tick_inc >= dah_threshold;

    // Append the new element below the ones already collected.
    can_append = release_edge && (element_count < CNT_W'(MAX_ELEMENTS));
    bits_app = element_bits;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (can_append && (CNT_W'(MAX_ELEMENTS - 1 - i) == element_count)) begin
        bits_app[i] = is_dah;
      end
    end
    cnt_app = can_append ? element_count + 1'b1 : element_count;

    // A character ends when the pattern is full, or after a long enough gap.
    // After a full pattern the count is cleared, so a gap in the same tick
    // never decodes a second time.
    pattern_full = release_edge && (cnt_app >= CNT_W'(MAX_ELEMENTS));
    gap_end = key_released && (tick_after_edge >= dah_threshold);
    do_decode = pattern_full || (gap_end && (cnt_app != '0));

    // Right-align the pattern and put a leading one above it for the table.
    shamt = CNT_W'(MAX_ELEMENTS) - cnt_app;
    code5 = 5'(bits_app >> shamt);
    lead = 6'd1 << cnt_app;
    table_idx = lead | ({1'b0, code5} & (lead - 6'd1));
    if (cnt_app == '0 || cnt_app > CNT_W'(TABLE_ELEMENTS)) begin
      decoded = CHAR_UNKNOWN;
    end else begin
      decoded = morse_lookup(table_idx);
    end

    key_pressed_next = !key_released;
    tick_count_next = gap_end ? '0 : tick_after_edge;
    if (pattern_full || gap_end) begin
      element_bits_next = '0;
      element_count_next = '0;
    end else begin
      element_bits_next = bits_app;
      element_count_next = cnt_app;
    end
    last_char_next = do_decode ? decoded : last_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dah_threshold <= DAH_THRESHOLD_RESET;
      key_pressed <= 1'b0;
      tick_count <= '0;
      element_bits <= '0;
      element_count <= '0;
      last_char <= CHAR_UNKNOWN;
      out_valid <= 1'b0;
    end else begin
      if (dah_threshold_we) begin
        dah_threshold <= dah_threshold_wdata;
      end
      if (accept) begin
        key_pressed <= key_pressed_next;
        tick_count <= tick_count_next;
        element_bits <= element_bits_next;
        element_count <= element_count_next;
        last_char <= last_char_next;
        out_valid <= 1'b1;
        out_code <= last_char_next;
        out_done <= do_decode;
      end else if (char_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The pattern never holds more elements than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above capacity");

  // Decoding a character always leaves an empty pattern behind.
  a_decode_clears: assert property (@(posedge clk) disable iff (rst)
    accept && do_decode |=> element_count == '0 && element_bits == '0)
    else $error("pattern not cleared after decode");

  // A result that reports a decoded character carries the stored character.
  a_done_code: assert property (@(posedge clk) disable iff (rst)
    accept && do_decode |=> out_valid && out_done && out_code == last_char)
    else $error("decoded result does not match stored character");

  // Any key edge restarts the tick count.
  a_edge_restart: assert property (@(posedge clk) disable iff (rst)
    accept && (press_edge || release_edge) |=> tick_count == '0)
    else $error("tick count not restarted on key edge");

endmodule

// ----- verif/morse_key_decoder_tb.sv -----
// Self-checking testbench for morse_key_decoder: directed key strokes, then random
// characters at several thresholds, each result beat checked against a tick predictor.
// Depends on mkd_pkg, mkd_key_if, mkd_char_if and the morse_key_decoder RTL.
`timescale 1ns / 1ps

module morse_key_decoder_tb;
  import mkd_pkg::*;

  localparam int ELEMS         = MAX_ELEMENTS_DEF;
  localparam int NUM_DIRECTED  = 24;
  localparam int PHASE_BEATS   = 450;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 1_500_000;

  // Character table indexed by a leading one above the MSB-first pattern (dah = 1).
  // Character i of the string sits at bits [8*(63-i) +: 8].
  localparam logic [64*8-1:0] MORSE_LUT = {"++ETIANM", "SURWDKGO", "HVF+L+PJBXCYZQ++",
                                           "54+3+++2+++++++1", "6+++++++7+++8+90"};

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              char_done;
  } char_beat_t;

  // One directed key stroke: press ticks (0 for none), then released ticks.
  // When typed is set, the last released beat carries the character written here.
  typedef struct packed {
    logic [THR_W-1:0]  thr;
    int unsigned       press;
    int unsigned       gap;
    bit                typed;
    logic [CHAR_W-1:0] ch;
    logic              done;
  } key_stroke_t;

  logic             clk;
  logic             rst;
  logic             dah_threshold_we;
  logic [THR_W-1:0] dah_threshold_wdata;

  mkd_key_if  key_bus ();
  mkd_char_if char_bus ();

  morse_key_decoder u_top (
    .clk                 (clk),
    .rst                 (rst),
    .dah_threshold_we    (dah_threshold_we),
    .dah_threshold_wdata (dah_threshold_wdata),
    .key_in              (key_bus),
    .char_out            (char_bus)
  );

  // Predicted decoder state, advanced once per accepted key beat.
  logic              key_down;
  logic [THR_W-1:0]  ticks_since_edge;
  logic [ELEMS-1:0]  element_pattern;
  logic [3:0]        element_total;
  logic [CHAR_W-1:0] shown_char;
  logic [THR_W-1:0]  dah_limit;

  // Characters still owed by the block, oldest first.
  char_beat_t  pending_chars[$];
  key_stroke_t directed_strokes[NUM_DIRECTED];

  int unsigned key_beats;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          quiet;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Idle lengths for both channels: mostly none or short, now and then long.
  // While quiet is set, neither side idles at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Looks up a collected pattern. Patterns longer than the table are unknown.
  function automatic logic [CHAR_W-1:0] pattern_char(input logic [ELEMS-1:0] pattern,
                                                     input logic [3:0] count);
    logic [5:0] index;
    if (count == 0 || count > TABLE_ELEMENTS) return CHAR_UNKNOWN;
    index = 6'((1 << count) | (pattern >> (ELEMS - count)));
    return MORSE_LUT[8*(63-index) +: CHAR_W];
  endfunction

  function automatic void clear_decoder_state();
    key_down         = 1'b0;
    ticks_since_edge = '0;
    element_pattern  = '0;
    element_total    = '0;
    shown_char       = CHAR_UNKNOWN;
    dah_limit        = DAH_THRESHOLD_RESET;
  endfunction

  // One millisecond tick: count with saturation, handle a key edge, then the
  // released-gap check that closes a pending character.
  task automatic decode_tick(input logic level, output char_beat_t beat);
    logic [THR_W-1:0] press_len;
    beat.char_done = 1'b0;
    if (ticks_since_edge != '1) ticks_since_edge = ticks_since_edge + 1'b1;
    if (!key_down && !level) begin
      // A press ends the released gap; its length is thrown away.
      key_down         = 1'b1;
      ticks_since_edge = '0;
    end else if (key_down && level) begin
      press_len        = ticks_since_edge;
      key_down         = 1'b0;
      ticks_since_edge = '0;
      if (element_total < ELEMS) begin
        element_pattern[ELEMS-1-element_total] = (press_len >= dah_limit);
        element_total++;
      end
      if (element_total >= ELEMS) begin
        shown_char      = pattern_char(element_pattern, element_total);
        beat.char_done  = 1'b1;
        element_pattern = '0;
        element_total   = '0;
      end
    end
    if (!key_down && ticks_since_edge >= dah_limit) begin
      if (element_total != 0) begin
        shown_char     = pattern_char(element_pattern, element_total);
        beat.char_done = 1'b1;
      end
      element_pattern  = '0;
      element_total    = '0;
      ticks_since_edge = '0;
    end
    beat.char_code = shown_char;
  endtask

  // Offers one key beat after a random idle stretch and waits until it is taken.
  // The prediction is made at the accepting edge. A typed beat replaces the
  // predicted one in the store, while the predictor still moves on.
  task automatic push_key(input logic level, input bit use_typed, input char_beat_t typed_beat);
    int unsigned idle;
    char_beat_t  beat;
    idle = pick_gap();
    if (idle != 0) begin
      key_bus.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    key_bus.valid     <= 1'b1;
    key_bus.key_level <= level;
    @(posedge clk);
    while (!key_bus.ready) @(posedge clk);
    decode_tick(level, beat);
    pending_chars.push_back(use_typed ? typed_beat : beat);
    key_beats++;
  endtask

  task automatic send_stroke(input int unsigned press, input int unsigned gap);
    repeat (press) push_key(1'b0, 1'b0, '0);
    repeat (gap) push_key(1'b1, 1'b0, '0);
  endtask

  // The threshold is only rewritten once every owed character has come back
  // and the block has had a few cycles to settle.
  task automatic load_threshold(input logic [THR_W-1:0] value);
    key_bus.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    dah_threshold_we    <= 1'b1;
    dah_threshold_wdata <= value;
    @(posedge clk);
    dah_threshold_we <= 1'b0;
    dah_limit = value;
  endtask

  // One random character. Most are well formed: dits shorter than the threshold,
  // dahs at or above it, short gaps inside and a long gap at the end. Some end
  // with a gap too short, so they run into the next one, and some are pure noise.
  task automatic send_random_character(input int unsigned thr);
    int unsigned n_elems;
    int unsigned press;
    int unsigned gap;
    int unsigned k;
    logic        level;
    bit          dah;
    quiet = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        level = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 3 * thr)) push_key(level, 1'b0, '0);
      end
    end else begin
      n_elems = $urandom_range(1, ELEMS);
      for (k = 0; k < n_elems; k++) begin
        // With a threshold of one no press can be a dit.
        dah = (thr < 2) || ($urandom_range(0, 1) == 1);
        if (!dah) press = $urandom_range(1, thr - 1);
        else if ($urandom_range(0, 7) == 0) press = $urandom_range(thr, 4 * thr);
        else press = $urandom_range(thr, thr + 2);
        if (k != n_elems - 1) gap = (thr < 2) ? 1 : $urandom_range(1, thr - 1);
        else if (n_elems == ELEMS || $urandom_range(0, 7) == 0) gap = $urandom_range(1, thr + 3);
        else gap = $urandom_range(thr + 1, thr + 4);
        send_stroke(press, gap);
      end
    end
  endtask

  // Result side: ready drops for random stretches and rises again for random stretches.
  initial begin
    int unsigned stall;
    char_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        char_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      char_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Every result beat is matched against the oldest owed character.
  always @(posedge clk) begin : check_chars
    char_beat_t want;
    if (char_bus.valid && char_bus.ready) begin
      if (pending_chars.size() == 0) begin
        $error("char_code: no beat expected, actual %0d", char_bus.char_code);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (char_bus.char_code !== want.char_code) begin
          $error("char_code: expected %0d, actual %0d", want.char_code, char_bus.char_code);
          mismatches++;
        end
        if (char_bus.char_done !== want.char_done) begin
          $error("char_done: expected %0d, actual %0d", want.char_done, char_bus.char_done);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned       i;
    int unsigned       k;
    int unsigned       phase_start;
    logic [THR_W-1:0]  random_thr[4];
    key_stroke_t       row;

    // Directed strokes. The threshold is two unless a row says otherwise, so a
    // one-tick press is a dit, a two-tick press a dah, and three released ticks,
    // the release itself included, close the character.
    directed_strokes = '{
      // Right after reset: released and nothing collected.
      '{16'd1000, 0, 1, 1'b1, CHAR_UNKNOWN, 1'b0},
      '{16'd2, 1, 3, 1'b1, 7'("E"), 1'b1},
      '{16'd2, 2, 3, 1'b1, 7'("T"), 1'b1},
      // Five dits end the character on the fifth release.
      '{16'd2, 1, 1, 1'b0, '0, 1'b0},
      '{16'd2, 1, 1, 1'b0, '0, 1'b0},
      '{16'd2, 1, 1, 1'b0, '0, 1'b0},
      '{16'd2, 1, 1, 1'b0, '0, 1'b0},
      '{16'd2, 1, 1, 1'b1, 7'("5"), 1'b1},
      // Five dahs.
      '{16'd2, 2, 1, 1'b0, '0, 1'b0},
      '{16'd2, 2, 1, 1'b0, '0, 1'b0},
      '{16'd2, 2, 1, 1'b0, '0, 1'b0},
      '{16'd2, 2, 1, 1'b0, '0, 1'b0},
      '{16'd2, 2, 1, 1'b1, 7'("0"), 1'b1},
      // Dit dit dah dah is not in the table.
      '{16'd2, 1, 1, 1'b0, '0, 1'b0},
      '{16'd2, 1, 1, 1'b0, '0, 1'b0},
      '{16'd2, 2, 1, 1'b0, '0, 1'b0},
      '{16'd2, 2, 3, 1'b1, CHAR_UNKNOWN, 1'b1},
      // A long idle gap with nothing collected, then a long press ending it.
      '{16'd2, 0, 5, 1'b0, '0, 1'b0},
      '{16'd2, 4, 3, 1'b1, 7'("T"), 1'b1},
      '{16'd2, 1, 1, 1'b0, '0, 1'b0},
      '{16'd2, 2, 3, 1'b1, 7'("A"), 1'b1},
      // Threshold zero: every press is a dah and is decoded on its own release.
      '{16'd0, 1, 1, 1'b1, 7'("T"), 1'b1},
      '{16'd0, 3, 2, 1'b0, '0, 1'b0},
      // Largest threshold: a short press is a dit and the character stays open,
      // so the last character is still shown and nothing is decoded.
      '{16'hFFFF, 3, 1, 1'b1, 7'("T"), 1'b0}
    };

    rst                 <= 1'b1;
    dah_threshold_we    <= 1'b0;
    dah_threshold_wdata <= '0;
    key_bus.valid       <= 1'b0;
    key_bus.key_level   <= 1'b1;
    key_beats  = 0;
    mismatches = 0;
    quiet      = 1'b0;
    clear_decoder_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_strokes[i];
      if (row.thr != dah_limit) load_threshold(row.thr);
      // Very long strokes run without idling to keep the run short.
      quiet = (row.press + row.gap > 1000);
      repeat (row.press) push_key(1'b0, 1'b0, '0);
      for (k = 1; k <= row.gap; k++)
        push_key(1'b1, row.typed && (k == row.gap), char_beat_t'{row.ch, row.done});
    end

    // Random characters at four thresholds: one, two rising random ones, then three.
    random_thr[0] = 16'd1;
    random_thr[1] = THR_W'($urandom_range(2, 6));
    random_thr[2] = THR_W'($urandom_range(7, 20));
    random_thr[3] = 16'd3;
    for (i = 0; i < 4; i++) begin
      load_threshold(random_thr[i]);
      phase_start = key_beats;
      while (key_beats - phase_start < PHASE_BEATS) send_random_character(random_thr[i]);
    end

    key_bus.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
